/* rtl/core/cswl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cswl_pkg
// Shared constants and types of the chunk stream valid length block.
// ----------------------------------------------------------------------------
package cswl_pkg;

  localparam int unsigned LengthBitsDef = 32;
  localparam int unsigned HeaderBytes   = 8;
  localparam int unsigned SizeOffset    = 4;
  localparam int unsigned SizeBits      = 32;
  localparam int unsigned RealLenBits   = 32;

  // result of one byte, valid when done is set
  typedef struct packed {
    logic                   done;
    logic [RealLenBits-1:0] real_length;
  } cswl_result_t;

endpackage

/* rtl/core/cswl_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cswl_byte_if / cswl_len_if
// Valid/ready channels for buffer bytes and committed lengths.
// ----------------------------------------------------------------------------
interface cswl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cswl_len_if;
  logic        valid;
  logic        ready;
  logic [31:0] real_length;

  modport source (output valid, output real_length, input ready);
  modport sink   (input valid, input real_length, output ready);
endinterface

/* rtl/core/cswl_chunk_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cswl_chunk_tracker
// Walks chunk headers and payloads one byte per transfer and keeps the end
// position of the last complete chunk.
// ----------------------------------------------------------------------------
module cswl_chunk_tracker
  import cswl_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LengthBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         advance_i,
  input  logic [7:0]   data_byte_i,
  input  logic         last_byte_i,
  output cswl_result_t result_o
);

  localparam int unsigned IdxBits = $clog2(HeaderBytes);

  logic [LENGTH_BITS-1:0] pos_q, pos_d;
  logic [LENGTH_BITS-1:0] commit_q, commit_d;
  logic [IdxBits-1:0]     hidx_q, hidx_d;
  logic [SizeBits-1:0]    size_q, size_d;
  logic [SizeBits-1:0]    left_q, left_d;
  logic                   in_pay_q, in_pay_d;
  logic [SizeBits-1:0]    size_new;
  logic [SizeBits-1:0]    byte_shifted;

  assign byte_shifted = {{(SizeBits-8){1'b0}}, data_byte_i}
                        << {hidx_q[IdxBits-2:0], 3'b000};

  always_comb begin
    pos_d    = (pos_q != {LENGTH_BITS{1'b1}}) ? pos_q + 1'b1 : pos_q;
    commit_d = commit_q;
    hidx_d   = hidx_q;
    size_d   = size_q;
    left_d   = left_q;
    in_pay_d = in_pay_q;
    size_new = size_q;
    if (!in_pay_q) begin
      // upper half of the header carries the little-endian size
      if (hidx_q[IdxBits-1]) begin
        size_new = size_q | byte_shifted;
      end
      size_d = size_new;
      hidx_d = hidx_q + 1'b1;
      if (hidx_q == IdxBits'(HeaderBytes - 1)) begin
        hidx_d = '0;
        size_d = '0;
        if (size_new == '0) begin
          commit_d = pos_d;
        end else begin
          left_d   = size_new;
          in_pay_d = 1'b1;
        end
      end
    end else begin
      left_d = left_q - 1'b1;
      if (left_q == SizeBits'(1)) begin
        in_pay_d = 1'b0;
        commit_d = pos_d;
      end
    end
  end

  always_comb begin
    result_o.done = advance_i & last_byte_i;
    if (LENGTH_BITS >= RealLenBits) begin
      result_o.real_length = commit_d[RealLenBits-1:0];
    end else begin
      result_o.real_length = RealLenBits'(commit_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      commit_q <= '0;
      hidx_q   <= '0;
      size_q   <= '0;
      left_q   <= '0;
      in_pay_q <= 1'b0;
    end else if (advance_i) begin
      if (last_byte_i) begin
        // buffer done, start over for the next one
        pos_q    <= '0;
        commit_q <= '0;
        hidx_q   <= '0;
        size_q   <= '0;
        left_q   <= '0;
        in_pay_q <= 1'b0;
      end else begin
        pos_q    <= pos_d;
        commit_q <= commit_d;
        hidx_q   <= hidx_d;
        size_q   <= size_d;
        left_q   <= left_d;
        in_pay_q <= in_pay_d;
      end
    end
  end

endmodule

/* rtl/core/chunk_stream_valid_length_core.sv */
`timescale 1ns / 1ps
// The length for a buffer appears in the cycle after its last byte transfer.
// Throughput: one byte per cycle while the output register is not full and stalled.
// A byte is taken while a length waits in the output register, unless that
// register is full and stalled.
// Reset (async, active low) clears the tracker and empties the output register.
// ----------------------------------------------------------------------------
// chunk_stream_valid_length_core
// Reports the byte length of a chunked buffer covered by complete chunks.
// ----------------------------------------------------------------------------
module chunk_stream_valid_length_core
  import cswl_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LengthBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  cswl_byte_if.sink  byte_i,
  cswl_len_if.source length_o
);

  cswl_result_t         result;
  logic                 advance;
  logic                 out_valid_q;
  logic [RealLenBits-1:0] out_len_q;

  assign byte_i.ready = !out_valid_q || length_o.ready;
  assign advance      = byte_i.valid && byte_i.ready;

  cswl_chunk_tracker #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_tracker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .data_byte_i(byte_i.data_byte),
    .last_byte_i(byte_i.last_byte),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (byte_i.ready) begin
      out_valid_q <= result.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result.done && byte_i.ready) begin
      out_len_q <= result.real_length;
    end
  end

  assign length_o.valid       = out_valid_q;
  assign length_o.real_length = out_len_q;

endmodule

/* rtl/core/cswl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cswl_checker
// Port-level checks of the chunk stream valid length block.
// ----------------------------------------------------------------------------
module cswl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_len_i
);

  // a stalled length holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_len_i))
    else $error("stalled length changed");

  // the last byte of a buffer yields a length in the next cycle
  a_last_gives_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> out_valid_i)
    else $error("no length after last byte");

  // other bytes never produce a length
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !in_last_i && (!out_valid_i || out_ready_i)
    |=> !out_valid_i)
    else $error("length without last byte");

  // a full, stalled output register blocks input
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("byte taken while output full");

endmodule

bind chunk_stream_valid_length_core cswl_checker u_cswl_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (byte_i.valid),
  .in_ready_i (byte_i.ready),
  .in_last_i  (byte_i.last_byte),
  .out_valid_i(length_o.valid),
  .out_ready_i(length_o.ready),
  .out_len_i  (length_o.real_length)
);
